>>> sv/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// shared widths, codes and types of the sphere frustum and contribution cull
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int WORD_W          = 32;
  localparam int RAD_W           = 31;
  localparam int PIDX_W          = 3;
  localparam int NUM_PLANES_DEF  = 6;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FOV_DEGREES     = 90;
  localparam int PIXEL_THRESHOLD = 1;
  localparam int FOV_SCALE       = 2 * FOV_DEGREES;
  localparam int FOV_SCALE_SQ    = FOV_SCALE * FOV_SCALE;
  localparam int SCALE_SQ_W      = $clog2(FOV_SCALE_SQ + 1);

  // frustum distance: three 64-bit products plus the shifted offset
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 3;

  // contribution: |delta| fits one word, three squares summed
  localparam int DIFF_W = WORD_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int RR_W   = 2 * RAD_W;
  localparam int LHS_W  = RR_W + SCALE_SQ_W;

  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CULL_NONE    = 2'd0,
    CULL_FRUSTUM = 2'd1,
    CULL_BOTH    = 2'd2,
    CULL_CONTRIB = 2'd3
  } cull_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CULL_MODE = 2'd0,
    CFG_CAMERA_X  = 2'd1,
    CFG_CAMERA_Y  = 2'd2,
    CFG_CAMERA_Z  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
    logic signed [WORD_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } vec3_t;

endpackage

>>> sv/sfc_plane_store.sv
// ----------------------------------------------------------------------------
// sfc_plane_store
// register file of frustum planes, cleared at reset, one plane written a beat
// ----------------------------------------------------------------------------
module sfc_plane_store #(
  parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [sfc_pkg::PIDX_W-1:0]  wr_idx,
  input  sfc_pkg::plane_t             wr_plane,
  output sfc_pkg::plane_t             planes [NUM_PLANES]
);
  import sfc_pkg::*;

  plane_t planes_r [NUM_PLANES];

  // an index past the last plane matches no entry and is dropped
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        planes_r[p] <= '0;
      end else if (wr_en && (wr_idx == PIDX_W'(p))) begin
        planes_r[p] <= wr_plane;
      end
    end
    assign planes[p] = planes_r[p];
  end

endmodule

>>> sv/sfc_frustum_lane.sv
// ----------------------------------------------------------------------------
// sfc_frustum_lane
// signed distance of the sphere to one plane, three register stages
// ----------------------------------------------------------------------------
module sfc_frustum_lane #(
  parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  sfc_pkg::plane_t            plane,
  input  sfc_pkg::vec3_t             center,
  input  logic [sfc_pkg::RAD_W-1:0]  radius,
  output logic                       outside
);
  import sfc_pkg::*;

  logic signed [PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r;
  logic signed [WORD_W:0]   dr_nxt, dr_r;
  logic signed [SUM_W-1:0]  sum1_nxt, sum2_nxt, sum1_r, sum2_r;
  logic signed [SUM_W-1:0]  plane_sum;
  logic                     neg_r;

  // stage 1: products and d + r
  assign pa_nxt = plane.a * center.x;
  assign pb_nxt = plane.b * center.y;
  assign pc_nxt = plane.c * center.z;
  assign dr_nxt = $signed({plane.d[WORD_W-1], plane.d}) + $signed({2'b00, radius});

  // stage 2: pairwise sums, the offset carries the fraction scale
  assign sum1_nxt = SUM_W'(pa_r) + SUM_W'(pb_r);
  assign sum2_nxt = SUM_W'(pc_r) + (SUM_W'(dr_r) <<< FRAC_BITS);

  // stage 3: final sum, sign says the sphere is wholly outside
  assign plane_sum = sum1_r + sum2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      pc_r   <= pc_nxt;
      dr_r   <= dr_nxt;
      sum1_r <= sum1_nxt;
      sum2_r <= sum2_nxt;
      neg_r  <= plane_sum[SUM_W-1];
    end
  end

  assign outside = neg_r;

endmodule

>>> sv/sfc_contrib.sv
// ----------------------------------------------------------------------------
// sfc_contrib
// projected size test: (180*r)^2 against squared distance to the camera
// ----------------------------------------------------------------------------
module sfc_contrib (
  input  logic                       clk,
  input  logic                       en,
  input  sfc_pkg::vec3_t             center,
  input  sfc_pkg::vec3_t             camera,
  input  logic [sfc_pkg::RAD_W-1:0]  radius,
  output logic                       reject
);
  import sfc_pkg::*;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [WORD_W-1:0] p,
                                                 input logic signed [WORD_W-1:0] q);
    logic signed [WORD_W:0] e;
    logic signed [WORD_W:0] m;
    e = $signed({p[WORD_W-1], p}) - $signed({q[WORD_W-1], q});
    m = -e;
    return e[WORD_W] ? m[DIFF_W-1:0] : e[DIFF_W-1:0];
  endfunction

  logic [DIFF_W-1:0]  dx_r, dy_r, dz_r;
  logic [RR_W-1:0]    rr_nxt, rr_r;
  logic [SQ_W-1:0]    sqx_nxt, sqy_nxt, sqz_nxt;
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r, sqz2_r;
  logic [LHS_W-1:0]   lhs_nxt, lhs_r, lhs2_r;
  logic [SQ_W:0]      dxy_nxt, dxy_r;
  logic [DIST_W-1:0]  dist2;

  // stage 1: deltas and r^2
  assign rr_nxt = RR_W'(radius) * RR_W'(radius);

  // stage 2: squares, scaled radius term
  assign sqx_nxt = SQ_W'(dx_r) * SQ_W'(dx_r);
  assign sqy_nxt = SQ_W'(dy_r) * SQ_W'(dy_r);
  assign sqz_nxt = SQ_W'(dz_r) * SQ_W'(dz_r);
  assign lhs_nxt = LHS_W'(rr_r) * LHS_W'(FOV_SCALE_SQ);

  // stage 3: partial distance sum
  assign dxy_nxt = (SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= abs_diff(center.x, camera.x);
      dy_r   <= abs_diff(center.y, camera.y);
      dz_r   <= abs_diff(center.z, camera.z);
      rr_r   <= rr_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      sqz_r  <= sqz_nxt;
      lhs_r  <= lhs_nxt;
      dxy_r  <= dxy_nxt;
      sqz2_r <= sqz_r;
      lhs2_r <= lhs_r;
    end
  end

  // last stage: full distance and compare, registered by the caller
  assign dist2  = DIST_W'(dxy_r) + DIST_W'(sqz2_r);
  assign reject = lhs2_r < (LHS_W'(dist2) * LHS_W'(PIXEL_THRESHOLD));

endmodule

>>> sv/sphere_frustum_contribution_cull.sv
// ----------------------------------------------------------------------------
// sphere_frustum_contribution_cull
// bounding sphere cull against a plane set and a projected size threshold
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tuser func, in_tdata plane/sphere
//  out_    | master    | out_tvalid/out_tready| out_tdata culled and reject flags
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one beat per cycle while out_tready takes each result; a test beat passes through
// the input register, product stage, two sum stages and output register to its result.
// load beats write the plane store at once and give no result.
// synchronous reset clears the plane store, sets cull_mode to 2, camera to 0.
// a stall at the output freezes every stage and drops in_tready in the same cycle.
// ----------------------------------------------------------------------------
module sphere_frustum_contribution_cull #(
  parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] func
  input  logic                            in_tuser,
  // [2:0] plane_index, [34:3] plane_a, [66:35] plane_b, [98:67] plane_c,
  // [130:99] plane_d, [162:131] center_x, [194:163] center_y,
  // [226:195] center_z, [257:227] radius, [263:258] zero
  input  logic [sfc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] culled, [1] frustum_reject, [2] contribution_reject, [7:3] zero
  output logic [sfc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfc_pkg::WORD_W-1:0]      cfg_data
);
  import sfc_pkg::*;

  logic                   en;
  logic                   in_beat;
  func_t                  in_func;
  logic [PIDX_W-1:0]      in_pidx;
  plane_t                 in_plane;
  vec3_t                  in_center;
  logic [RAD_W-1:0]       in_radius;

  cull_mode_t             cull_mode_r;
  vec3_t                  camera_r;

  vec3_t                  center_r;
  logic [RAD_W-1:0]       radius_r;
  logic                   v1_r, v2_r, v3_r, v4_r, v5_r;

  plane_t                 planes [NUM_PLANES];
  logic [NUM_PLANES-1:0]  outside;
  logic                   frustum_rej;
  logic                   contrib_rej;
  logic                   culled;
  logic [2:0]             flags_r;

  // whole pipeline moves together unless the output holds a result that out_tready does not take
  assign en        = !v5_r || out_tready;
  assign in_tready = en;
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_func     = func_t'(in_tuser);
  assign in_pidx     = in_tdata[2:0];
  assign in_plane.a  = $signed(in_tdata[34:3]);
  assign in_plane.b  = $signed(in_tdata[66:35]);
  assign in_plane.c  = $signed(in_tdata[98:67]);
  assign in_plane.d  = $signed(in_tdata[130:99]);
  assign in_center.x = $signed(in_tdata[162:131]);
  assign in_center.y = $signed(in_tdata[194:163]);
  assign in_center.z = $signed(in_tdata[226:195]);
  assign in_radius   = in_tdata[257:227];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cull_mode_r <= CULL_BOTH;
      camera_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CULL_MODE: cull_mode_r <= cull_mode_t'(cfg_data[1:0]);
        CFG_CAMERA_X:  camera_r.x  <= $signed(cfg_data);
        CFG_CAMERA_Y:  camera_r.y  <= $signed(cfg_data);
        CFG_CAMERA_Z:  camera_r.z  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  sfc_plane_store #(
    .NUM_PLANES (NUM_PLANES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_beat && (in_func == FUNC_LOAD)),
    .wr_idx   (in_pidx),
    .wr_plane (in_plane),
    .planes   (planes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_beat && (in_func == FUNC_TEST);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      center_r <= in_center;
      radius_r <= in_radius;
    end
  end

  // lanes read the store with the registered sphere, before any later load lands
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    sfc_frustum_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .plane   (planes[p]),
      .center  (center_r),
      .radius  (radius_r),
      .outside (outside[p])
    );
  end

  sfc_contrib u_contrib (
    .clk    (clk),
    .en     (en),
    .center (center_r),
    .camera (camera_r),
    .radius (radius_r),
    .reject (contrib_rej)
  );

  assign frustum_rej = |outside;

  always_comb begin
    unique case (cull_mode_r)
      CULL_NONE:    culled = 1'b0;
      CULL_FRUSTUM: culled = frustum_rej;
      CULL_BOTH:    culled = frustum_rej || contrib_rej;
      CULL_CONTRIB: culled = contrib_rej;
      default:      culled = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= {contrib_rej, frustum_rej, culled};
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {{(OUT_DATA_W-3){1'b0}}, flags_r};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while a result is stalled");

  a_culled_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[1] || out_tdata[2]))
    else $error("culled without a reject flag");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
